>>> design/mwpv_pkg.sv
// Shared constants, types and helpers for the mecanum wheel velocity loop.
package mwpv_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DT_FRAC    = 24;
    localparam int GAIN_FRAC  = 8;
    localparam int OUT_W      = 21;
    localparam int WHEELS     = 4;

    localparam logic [2:0] REG_GAIN_ONE   = 3'd0;
    localparam logic [2:0] REG_GAIN_TWO   = 3'd1;
    localparam logic [2:0] REG_GAIN_THREE = 3'd2;
    localparam logic [2:0] REG_GAIN_FOUR  = 3'd3;
    localparam logic [2:0] REG_INT_UPPER  = 3'd4;
    localparam logic [2:0] REG_INT_LOWER  = 3'd5;
    localparam logic [2:0] REG_INV_RADIUS = 3'd6;
    localparam logic [2:0] REG_BASE_SUM   = 3'd7;

    localparam logic signed [31:0] EFFORT_LIMIT = 32'sd655360;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SW,       // s * wz
        ST_ROW,      // row sum and radius scaling
        ST_DES,
        ST_INC,      // e * dt
        ST_DIV,      // derivative divide
        ST_KP,
        ST_KI,
        ST_KD,
        ST_EFF,
        ST_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

>>> design/mwpv_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, 33x33 to 66 bits.
module mwpv_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [32:0]  i_a,
    input  logic signed [32:0]  i_b,
    output logic                o_done,
    output logic signed [65:0]  o_p
);
    import mwpv_pkg::*;

    logic signed [65:0] r_acc, n_acc;
    logic signed [65:0] r_mcand, n_mcand;
    logic [32:0]        r_mplier, n_mplier;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;

    always_comb begin
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_cnt    = r_cnt;
        n_busy   = r_busy;
        n_done   = 1'b0;
        if (i_start) begin
            n_acc    = '0;
            n_mcand  = 66'(i_a);
            n_mplier = i_b;
            n_cnt    = '0;
            n_busy   = 1'b1;
        end else if (r_busy) begin
            // top bit of the multiplier carries negative weight
            if (r_mplier[0]) begin
                if (r_cnt == 6'd32)
                    n_acc = r_acc - r_mcand;
                else
                    n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand <<< 1;
            n_mplier = r_mplier >> 1;
            n_cnt    = r_cnt + 6'd1;
            if (r_cnt == 6'd32) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

>>> design/mwpv_div.sv
// Restoring divider, one quotient bit per cycle; quotient truncated toward zero.
module mwpv_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [57:0]  i_num,
    input  logic        [31:0]  i_den,      // positive
    output logic                o_done,
    output logic signed [57:0]  o_quo
);
    import mwpv_pkg::*;

    logic [57:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [33:0] trial;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_q[57]} - {2'b00, r_den};
        if (i_start) begin
            n_neg  = i_num[57];
            n_q    = i_num[57] ? 58'(-i_num) : 58'(i_num);
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[33]) begin
                n_rem = trial[32:0];
                n_q   = {r_q[56:0], 1'b1};
            end else begin
                n_rem = {r_rem[31:0], r_q[57]};
                n_q   = {r_q[56:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd57) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? 58'(-$signed(r_q)) : $signed(r_q);

endmodule

>>> design/mecanum_wheel_pid_velocity_loop_unit.sv
// Top level: mecanum inverse kinematics and four PID loops on serial arithmetic.
// Sequence from an input beat to o_valid: s * wz, then per wheel five multiplies on the
//   shared bit-serial multiplier, one divide on the bit-serial divider and a state each
//   for the error and the effort, then the ST_OUT state raises o_valid. One item at a
//   time: the next beat is taken the cycle after the result beat. A non-positive time
//   step is dropped with no result and ready stays high.
// Reset (synchronous, active low) clears control state, the PID state and
//   loads the register defaults.
module mecanum_wheel_pid_velocity_loop_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_turn_rate,
    input  logic signed [31:0] i_forward_speed,
    input  logic signed [31:0] i_side_speed,
    input  logic signed [31:0] i_time_step,
    input  logic signed [31:0] i_speed_wheel_one,
    input  logic signed [31:0] i_speed_wheel_two,
    input  logic signed [31:0] i_speed_wheel_three,
    input  logic signed [31:0] i_speed_wheel_four,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [20:0] o_effort_one,
    output logic signed [20:0] o_effort_two,
    output logic signed [20:0] o_effort_three,
    output logic signed [20:0] o_effort_four,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data
);
    import mwpv_pkg::*;

    logic [47:0]        r_gain [WHEELS];
    logic signed [31:0] r_upper, r_lower;
    logic [31:0]        r_inv_r, r_base;
    logic signed [31:0] r_integ [WHEELS];
    logic signed [31:0] r_lerr  [WHEELS];

    logic signed [31:0] r_wz, r_vx, r_vy, r_dt;
    logic signed [31:0] r_meas [WHEELS];
    logic signed [31:0] r_sw, r_e, r_inew, r_der;
    logic signed [48:0] r_acc;
    logic signed [20:0] r_eff [WHEELS];
    logic [1:0]         r_w;
    logic               r_ovalid;

    t_state r_st, n_st;
    logic   mul_start, div_start;
    logic signed [32:0] mul_a, mul_b;
    logic   mul_done, div_done;
    logic signed [65:0] mul_p;
    logic signed [57:0] div_q;
    logic   r_go;   // first cycle of a state launches its unit

    mwpv_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start),
        .i_a(mul_a), .i_b(mul_b), .o_done(mul_done), .o_p(mul_p)
    );

    mwpv_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(58'(($signed(66'(r_e)) - 66'(r_lerr[r_w])) <<< DT_FRAC)),
        .i_den(r_dt), .o_done(div_done), .o_quo(div_q)
    );

    logic signed [31:0] row, des, eri, sum_i, kp, ki, kd, effv;
    logic signed [65:0] row_x, sh_eff;
    logic signed [47:0] g;
    logic               accept;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_st == ST_IDLE) && !r_ovalid;

    always_comb begin
        g     = r_gain[r_w];
        kp    = 32'($signed(g[47:32]));
        ki    = 32'($signed(g[31:16]));
        kd    = 32'($signed(g[15:0]));
        case (r_w)
            2'd0:    row_x = 66'(r_vx) - 66'(r_sw) - 66'(r_vy);
            2'd1:    row_x = 66'(r_vx) + 66'(r_sw) + 66'(r_vy);
            2'd2:    row_x = 66'(r_vx) + 66'(r_sw) - 66'(r_vy);
            default: row_x = 66'(r_vx) - 66'(r_sw) + 66'(r_vy);
        endcase
        row   = sat32(row_x);
        des   = sat32(mul_p >>> FRAC_BITS);
        eri   = sat32(mul_p >>> DT_FRAC);
        sum_i = sat32(66'(r_integ[r_w]) + 66'(eri));
        if (sum_i > r_upper) sum_i = r_upper;
        if (sum_i < r_lower) sum_i = r_lower;
        sh_eff = 66'(r_acc) >>> GAIN_FRAC;
        if (sh_eff > 66'(EFFORT_LIMIT))       effv = EFFORT_LIMIT;
        else if (sh_eff < -66'(EFFORT_LIMIT)) effv = -EFFORT_LIMIT;
        else                                  effv = sh_eff[31:0];

        mul_a     = '0;
        mul_b     = '0;
        mul_start = 1'b0;
        div_start = 1'b0;
        n_st      = r_st;
        case (r_st)
            ST_IDLE: if (accept && i_time_step > 0) n_st = ST_SW;
            ST_SW: begin
                mul_a = {1'b0, r_base}; mul_b = 33'(r_wz);
                mul_start = r_go;
                if (mul_done) n_st = ST_ROW;
            end
            ST_ROW: begin
                mul_a = {1'b0, r_inv_r}; mul_b = 33'(row);
                mul_start = r_go;
                if (mul_done) n_st = ST_DES;
            end
            ST_DES: n_st = ST_INC;
            ST_INC: begin
                mul_a = 33'(r_e); mul_b = 33'(r_dt);
                mul_start = r_go;
                if (mul_done) n_st = ST_DIV;
            end
            ST_DIV: begin
                div_start = r_go;
                if (div_done) n_st = ST_KP;
            end
            ST_KP: begin
                mul_a = 33'(kp); mul_b = 33'(r_e);
                mul_start = r_go;
                if (mul_done) n_st = ST_KI;
            end
            ST_KI: begin
                mul_a = 33'(ki); mul_b = 33'(r_inew);
                mul_start = r_go;
                if (mul_done) n_st = ST_KD;
            end
            ST_KD: begin
                mul_a = 33'(kd); mul_b = 33'(r_der);
                mul_start = r_go;
                if (mul_done) n_st = ST_EFF;
            end
            ST_EFF:  n_st = (r_w == 2'd3) ? ST_OUT : ST_ROW;
            ST_OUT:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
            r_w      <= '0;
            r_upper  <= 32'sd65536;
            r_lower  <= -32'sd65536;
            r_inv_r  <= 32'd65536;
            r_base   <= 32'd65536;
            for (int k = 0; k < WHEELS; k++) begin
                r_gain[k]  <= '0;
                r_integ[k] <= '0;
                r_lerr[k]  <= '0;
            end
        end else begin
            r_st <= n_st;
            r_go <= (n_st != r_st);
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GAIN_ONE:   r_gain[0] <= i_cfg_data;
                    REG_GAIN_TWO:   r_gain[1] <= i_cfg_data;
                    REG_GAIN_THREE: r_gain[2] <= i_cfg_data;
                    REG_GAIN_FOUR:  r_gain[3] <= i_cfg_data;
                    REG_INT_UPPER:  r_upper   <= i_cfg_data[31:0];
                    REG_INT_LOWER:  r_lower   <= i_cfg_data[31:0];
                    REG_INV_RADIUS: r_inv_r   <= i_cfg_data[31:0];
                    REG_BASE_SUM:   r_base    <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            case (r_st)
                ST_IDLE: r_w <= '0;
                ST_SW:   if (mul_done) r_sw <= sat32(mul_p >>> FRAC_BITS);
                ST_DES:  r_e <= sat32(66'(des) - 66'(r_meas[r_w]));
                ST_INC:  if (mul_done) r_inew <= sum_i;
                ST_DIV:  if (div_done) r_der <= sat32(66'(div_q));
                ST_KP:   if (mul_done) r_acc <= 49'(mul_p);
                ST_KI:   if (mul_done) r_acc <= r_acc + 49'(mul_p);
                ST_KD:   if (mul_done) r_acc <= r_acc + 49'(mul_p);
                ST_EFF: begin
                    r_eff[r_w]   <= effv[20:0];
                    r_integ[r_w] <= r_inew;
                    r_lerr[r_w]  <= r_e;
                    r_w          <= r_w + 2'd1;
                end
                ST_OUT:  r_ovalid <= 1'b1;
                default: ;
            endcase
        end
        // desired speed held in r_sw slot reuse avoided: keep in r_e path
        if (accept) begin
            r_wz <= i_turn_rate;
            r_vx <= i_forward_speed;
            r_vy <= i_side_speed;
            r_dt <= i_time_step;
            r_meas[0] <= i_speed_wheel_one;
            r_meas[1] <= i_speed_wheel_two;
            r_meas[2] <= i_speed_wheel_three;
            r_meas[3] <= i_speed_wheel_four;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_effort_one   = r_eff[0];
    assign o_effort_two   = r_eff[1];
    assign o_effort_three = r_eff[2];
    assign o_effort_four  = r_eff[3];

endmodule

>>> tb/tb_mecanum_wheel_pid_velocity_loop_unit.sv
// Self-checking testbench for the mecanum wheel PID velocity loop unit.
module tb_mecanum_wheel_pid_velocity_loop_unit;
    import mwpv_pkg::*;

    localparam int SETTLE_CYCLES = 1100;   // one full item through the serial datapath
    localparam int STALL_LIMIT   = 20000;

    typedef struct {
        logic signed [31:0] turn;
        logic signed [31:0] fwd;
        logic signed [31:0] side;
        logic signed [31:0] dt;
        logic signed [31:0] speed[4];
    } t_tick;

    typedef struct {
        logic signed [20:0] eff[4];
    } t_efforts;

    typedef struct {
        logic [47:0] gains[4];
        logic [31:0] upper;
        logic [31:0] lower;
        logic [31:0] inv_r;
        logic [31:0] base;
    } t_loop_cfg;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_turn_rate = '0;
    logic signed [31:0] i_forward_speed = '0;
    logic signed [31:0] i_side_speed = '0;
    logic signed [31:0] i_time_step = '0;
    logic signed [31:0] i_speed_wheel_one = '0;
    logic signed [31:0] i_speed_wheel_two = '0;
    logic signed [31:0] i_speed_wheel_three = '0;
    logic signed [31:0] i_speed_wheel_four = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [20:0] o_effort_one;
    logic signed [20:0] o_effort_two;
    logic signed [20:0] o_effort_three;
    logic signed [20:0] o_effort_four;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [47:0]        i_cfg_data = '0;

    mecanum_wheel_pid_velocity_loop_unit dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    t_loop_cfg   cfg_now;
    longint      integ_state[4];
    longint      err_state[4];
    t_efforts    effort_queue[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          errors = 0;
    int          ticks_sent = 0;
    int          ticks_dropped = 0;
    int          beats_checked = 0;
    int          stall_cycles = 0;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Advances the PID state; returns 0 when the tick is dropped.
    function automatic bit compute_efforts(input t_tick t, output t_efforts r);
        longint wz, vx, vy, dt, sw, row, des, e, inc, integ, deriv, acc, eff;
        longint upper, lower;
        logic signed [15:0] kp, ki, kd;
        wz = longint'(t.turn);
        vx = longint'(t.fwd);
        vy = longint'(t.side);
        dt = longint'(t.dt);
        if (dt <= 0) return 1'b0;
        upper = longint'($signed(cfg_now.upper));
        lower = longint'($signed(cfg_now.lower));
        sw = clip32((longint'(cfg_now.base) * wz) >>> FRAC_BITS);
        for (int i = 0; i < WHEELS; i++) begin
            row = vx + ((i == 0 || i == 3) ? -sw : sw) + ((i == 0 || i == 2) ? -vy : vy);
            row = clip32(row);
            des = clip32((longint'(cfg_now.inv_r) * row) >>> FRAC_BITS);
            e = clip32(des - longint'(t.speed[i]));
            inc = clip32((e * dt) >>> DT_FRAC);
            integ = clip32(integ_state[i] + inc);
            if (integ > upper) integ = upper;
            if (integ < lower) integ = lower;
            deriv = clip32(((e - err_state[i]) * 64'sd16777216) / dt);
            kp = cfg_now.gains[i][47:32];
            ki = cfg_now.gains[i][31:16];
            kd = cfg_now.gains[i][15:0];
            acc = longint'(kp) * e + longint'(ki) * integ + longint'(kd) * deriv;
            eff = acc >>> GAIN_FRAC;
            if (eff > 64'sd655360) eff = 64'sd655360;
            if (eff < -64'sd655360) eff = -64'sd655360;
            integ_state[i] = integ;
            err_state[i] = e;
            r.eff[i] = eff[20:0];
        end
        return 1'b1;
    endfunction

    // Writes every register in turn; called on a clock edge.
    task automatic load_config(input t_loop_cfg c);
        logic [47:0] vals[8];
        for (int i = 0; i < 4; i++) vals[i] = c.gains[i];
        vals[REG_INT_UPPER]  = {16'b0, c.upper};
        vals[REG_INT_LOWER]  = {16'b0, c.lower};
        vals[REG_INV_RADIUS] = {16'b0, c.inv_r};
        vals[REG_BASE_SUM]   = {16'b0, c.base};
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_now = c;
        @(posedge i_clk);
    endtask

    // Drains the pipe so that config can be changed safely.
    task automatic settle();
        i_valid <= 1'b0;
        while (effort_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_tick(input t_tick t);
        t_efforts r;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid             <= 1'b1;
        i_turn_rate         <= t.turn;
        i_forward_speed     <= t.fwd;
        i_side_speed        <= t.side;
        i_time_step         <= t.dt;
        i_speed_wheel_one   <= t.speed[0];
        i_speed_wheel_two   <= t.speed[1];
        i_speed_wheel_three <= t.speed[2];
        i_speed_wheel_four  <= t.speed[3];
        do @(posedge i_clk); while (!o_ready);
        ticks_sent++;
        if (compute_efforts(t, r)) effort_queue.push_back(r);
        else ticks_dropped++;
    endtask

    function automatic logic signed [31:0] rand_q(input int full_pct);
        if ($urandom_range(99) < full_pct) return $urandom;
        return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endfunction

    function automatic t_tick rand_tick();
        t_tick t;
        int sel;
        t.turn = rand_q(25);
        t.fwd  = rand_q(25);
        t.side = rand_q(25);
        for (int i = 0; i < 4; i++) t.speed[i] = rand_q(25);
        sel = $urandom_range(99);
        if (sel < 8) t.dt = (sel < 3) ? 32'sd0 : -$signed({1'b0, 31'($urandom)});
        else if (sel < 20) t.dt = {1'b0, 31'($urandom)} | 32'sd1;
        else t.dt = $urandom_range(1, 1 << 25);
        return t;
    endfunction

    function automatic t_loop_cfg rand_config();
        t_loop_cfg c;
        logic [15:0] g;
        bit wild;
        wild = ($urandom_range(3) == 0);
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) begin
                g = wild ? 16'($urandom) : 16'($signed($urandom_range(0, 1024)) - 512);
                c.gains[i][47 - 16 * k -: 16] = g;
            end
        end
        c.upper = wild ? $urandom : $urandom_range(0, 1 << 20);
        c.lower = wild ? $urandom : -$signed($urandom_range(0, 1 << 20));
        c.inv_r = wild ? $urandom : $urandom_range(0, 1 << 19);
        c.base  = wild ? $urandom : $urandom_range(0, 1 << 18);
        return c;
    endfunction

    function automatic t_tick flat_tick(input logic signed [31:0] cmd,
                                        input logic signed [31:0] dt,
                                        input logic signed [31:0] meas);
        t_tick t;
        t.turn = cmd;
        t.fwd  = cmd;
        t.side = cmd;
        t.dt   = dt;
        for (int i = 0; i < 4; i++) t.speed[i] = meas;
        return t;
    endfunction

    task automatic test_directed();
        t_loop_cfg c;
        t_tick t;
        for (int i = 0; i < 4; i++) c.gains[i] = {16'h0100, 16'h0080, 16'h0010};
        c.upper = 32'h0001_0000;
        c.lower = 32'hFFFF_0000;
        c.inv_r = 32'h0001_0000;
        c.base  = 32'h0001_0000;
        load_config(c);
        send_tick(flat_tick(0, 32'sh0100_0000, 0));
        send_tick(flat_tick(32'sh0001_0000, 32'sh0100_0000, 0));
        send_tick(flat_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
        send_tick(flat_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        // non-positive periods leave the loop state alone
        send_tick(flat_tick(32'sh0002_0000, 32'sh0000_0000, 0));
        send_tick(flat_tick(32'sh0002_0000, -32'sh1, 0));
        send_tick(flat_tick(32'sh0002_0000, 32'sh8000_0000, 0));
        // tiny period: derivative saturates
        send_tick(flat_tick(32'sh0000_8000, 32'sh1, 32'sh0000_1000));
        t = flat_tick(32'sh0001_0000, 32'sh0040_0000, 0);
        t.side = -32'sh0003_0000;
        t.speed[1] = 32'sh7FFF_FFFF;
        t.speed[2] = 32'sh8000_0000;
        send_tick(t);
        settle();
        // crossed bounds, gains at the negative and positive edges
        c.upper = 32'hFFFF_0000;
        c.lower = 32'h0001_0000;
        c.gains[0] = {16'h8000, 16'h8000, 16'h8000};
        c.gains[1] = {16'h7FFF, 16'h7FFF, 16'h7FFF};
        c.gains[2] = {16'h0000, 16'h7FFF, 16'h0000};
        c.gains[3] = {16'hFFFF, 16'h0001, 16'hFF00};
        load_config(c);
        send_tick(flat_tick(32'sh0000_4000, 32'sh0100_0000, 0));
        send_tick(flat_tick(-32'sh0000_4000, 32'sh0080_0000, 32'sh0000_0100));
        send_tick(flat_tick(32'sh0000_0001, 32'sh0100_0000, -32'sh0000_0001));
        settle();
        // geometry and bounds at their extremes
        c.upper = 32'h7FFF_FFFF;
        c.lower = 32'h8000_0000;
        c.inv_r = 32'hFFFF_FFFF;
        c.base  = 32'hFFFF_FFFF;
        load_config(c);
        send_tick(flat_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
        send_tick(flat_tick(32'sh8000_0000, 32'sh0000_0001, 32'sh7FFF_FFFF));
        send_tick(flat_tick(32'sh0000_0001, 32'sh0100_0000, 32'sh8000_0000));
        send_tick(flat_tick(-32'sh0000_0001, 32'sh0200_0000, 0));
        settle();
        c.inv_r = 32'h0;
        c.base  = 32'h0;
        c.upper = 32'h0;
        c.lower = 32'h0;
        for (int i = 0; i < 4; i++) c.gains[i] = '0;
        load_config(c);
        send_tick(flat_tick(32'sh7FFF_FFFF, 32'sh0100_0000, 32'sh1234_5678));
        send_tick(flat_tick(32'sh8000_0000, 32'sh0100_0000, -32'sh1234_5678));
        settle();
    endtask

    task automatic test_random(input int phases, input int ticks_per_phase);
        for (int p = 0; p < phases; p++) begin
            case ((p * 3) / phases)
                0: begin send_idle_pct = 26; recv_idle_pct = 64; end
                1: begin send_idle_pct = 64; recv_idle_pct = 26; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            load_config(rand_config());
            repeat (ticks_per_phase) send_tick(rand_tick());
            settle();
        end
    endtask

    // result checker, ready driver and watchdog
    always @(posedge i_clk) begin
        t_efforts exp_r;
        logic signed [20:0] got[4];
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got[0] = o_effort_one;
            got[1] = o_effort_two;
            got[2] = o_effort_three;
            got[3] = o_effort_four;
            if (effort_queue.size() == 0) begin
                $display("%0t: unexpected beat, efforts %0d %0d %0d %0d",
                         $time, got[0], got[1], got[2], got[3]);
                errors++;
            end else begin
                exp_r = effort_queue.pop_front();
                beats_checked++;
                for (int i = 0; i < 4; i++) begin
                    if (got[i] !== exp_r.eff[i]) begin
                        $display("%0t: wheel %0d effort exp %0d got %0d",
                                 $time, i + 1, exp_r.eff[i], got[i]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < 4; i++) begin
            integ_state[i] = 0;
            err_state[i] = 0;
            cfg_now.gains[i] = '0;
        end
        cfg_now.upper = 32'h0001_0000;
        cfg_now.lower = 32'hFFFF_0000;
        cfg_now.inv_r = 32'h0001_0000;
        cfg_now.base  = 32'h0001_0000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(9, 148);
        if (effort_queue.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, effort_queue.size());
            errors++;
        end
        $display("Ran %0d ticks (%0d dropped for a non-positive period), %0d effort beats checked",
                 ticks_sent, ticks_dropped, beats_checked);
        $display("Covered crossed and extreme bounds, saturating geometry and mixed idling.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> mecanum_wheel_pid_velocity_loop_unit.f
design/mwpv_pkg.sv
design/mwpv_mul.sv
design/mwpv_div.sv
design/mecanum_wheel_pid_velocity_loop_unit.sv
tb/tb_mecanum_wheel_pid_velocity_loop_unit.sv
